@@ rtl/lsdc_pkg.sv @@
// ----------------------------------------------------------------------------
// lsdc_pkg
// Shared constants for the linear sieve divisor counter: default sizes,
// table field widths, saturation limits and configuration register codes.
// ----------------------------------------------------------------------------
package lsdc_pkg;

    // Default sizes
    localparam int MAX_N_DEF       = 65536;
    localparam int PRIME_DEPTH_DEF = 8192;
    localparam int IDX_W_DEF       = $clog2(MAX_N_DEF + 1);

    // Table field widths
    localparam int COUNT_W = 8;
    localparam int EXP_W   = 5;

    // Table values and saturation limits
    localparam logic [COUNT_W-1:0] COUNT_ONE   = 8'd1;
    localparam logic [COUNT_W-1:0] COUNT_PRIME = 8'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
    localparam logic [EXP_W-1:0]   EXP_PRIME   = 5'd1;
    localparam logic [EXP_W-1:0]   EXP_MAX     = 5'd31;

    // Configuration port
    localparam int   APB_AW          = 3;
    localparam int   APB_DW          = 32;
    localparam logic REG_UPPER_LIMIT = 1'b0;

    // upper_limit register: fixed width and reset value
    localparam int                       UPPER_LIMIT_W     = 17;
    localparam logic [UPPER_LIMIT_W-1:0] UPPER_LIMIT_RESET = 17'd65536;

endpackage

@@ rtl/lsdc_div.sv @@
// ----------------------------------------------------------------------------
// lsdc_div
// Restoring radix-2 divider: one quotient bit per cycle. Results hold until
// the next start.
// ----------------------------------------------------------------------------
module lsdc_div #(
    parameter int W = lsdc_pkg::IDX_W_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder,
    output logic         done
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0]       rem_sh;
    logic [W:0]       rem_sub;
    logic             fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[W-1]};
        fits    = (rem_sh >= {1'b0, dsr_reg});
        rem_sub = rem_sh - {1'b0, dsr_reg};
    end

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[W-2:0], fits};
            rem_reg <= fits ? rem_sub[W-1:0] : rem_sh[W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

@@ rtl/linear_sieve_divisor_count.sv @@
// ----------------------------------------------------------------------------
// linear_sieve_divisor_count
// Linear sieve that reports the divisor count of each integer from 1 up to a
// programmable limit, one integer per input beat.
// ----------------------------------------------------------------------------
// A beat with restart set reports index 1 (count 1) and then sweeps the
// composite marks clear, one entry per cycle, from the highest index marked
// since the last sweep down to 0; after reset the sweep covers all MAX_N+1
// entries. No beat is taken during a sweep. A beat without restart reports
// the next index: a table lookup, bookkeeping and result hand-off, plus a
// divisibility test through the shared bit-serial divider for every prime
// the walk tries within the limit, plus a count update through the same
// divider for the prime that divides the index; a walk without a divisor
// stops at the end of the prime list or at a product past the limit. A beat
// past the limit gives no result. The result sits in an output register, so
// the next beat is taken while it waits.
// ----------------------------------------------------------------------------
module linear_sieve_divisor_count #(
    parameter  int MAX_N       = lsdc_pkg::MAX_N_DEF,
    parameter  int PRIME_DEPTH = lsdc_pkg::PRIME_DEPTH_DEF,
    localparam int IDX_W       = $clog2(MAX_N + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsdc_pkg::APB_AW-1:0]   paddr,
    input  logic [lsdc_pkg::APB_DW-1:0]   pwdata,
    output logic [lsdc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    // input channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          restart,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [IDX_W-1:0]              index,
    output logic [lsdc_pkg::COUNT_W-1:0]  divisor_count,
    output logic                          last
);

    localparam int DW     = lsdc_pkg::APB_DW;
    localparam int CW     = lsdc_pkg::COUNT_W;
    localparam int EW     = lsdc_pkg::EXP_W;
    localparam int LIM_W  = lsdc_pkg::UPPER_LIMIT_W;
    localparam int CMP_W  = (IDX_W > LIM_W) ? IDX_W : LIM_W;
    localparam int PT_W   = $clog2(PRIME_DEPTH + 1);
    localparam int PL_AW  = (PRIME_DEPTH > 1) ? $clog2(PRIME_DEPTH) : 1;
    localparam int PROD_W = 2 * IDX_W;
    localparam int CMUL_W = CW + EW + 1;

    // Sequencer states
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_CLR  = 4'd0;
    localparam logic [ST_W-1:0] S_IDLE = 4'd1;
    localparam logic [ST_W-1:0] S_RD   = 4'd2;
    localparam logic [ST_W-1:0] S_CHK  = 4'd3;
    localparam logic [ST_W-1:0] S_PRD  = 4'd4;
    localparam logic [ST_W-1:0] S_PMUL = 4'd5;
    localparam logic [ST_W-1:0] S_PCMP = 4'd6;
    localparam logic [ST_W-1:0] S_PDIV = 4'd7;
    localparam logic [ST_W-1:0] S_CDIV = 4'd8;
    localparam logic [ST_W-1:0] S_CWR  = 4'd9;
    localparam logic [ST_W-1:0] S_OUT  = 4'd10;

    // Control state
    logic [ST_W-1:0]   state_reg, state_next;
    logic [LIM_W-1:0]  lim_reg;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [PT_W-1:0]   pt_reg, pt_next;
    logic [PT_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]  sweep_reg, sweep_next;
    logic [IDX_W-1:0]  dirty_top_reg, dirty_top_next;
    logic              restart_pend_reg, restart_pend_next;
    logic              out_valid_reg;

    // Working values
    logic [CW-1:0]     ci_reg, ci_next;
    logic [EW-1:0]     ei_reg, ei_next;
    logic [IDX_W-1:0]  p_reg, p_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [CMUL_W-1:0] cmul_reg, cmul_next;

    // Result register
    logic [IDX_W-1:0]  out_idx_reg;
    logic [CW-1:0]     out_cnt_reg;
    logic              out_last_reg;
    logic              out_load;

    // Tables
    logic              mark_mem  [0:MAX_N];
    logic [CW-1:0]     cnt_mem   [0:MAX_N];
    logic [EW-1:0]     exp_mem   [0:MAX_N];
    logic [IDX_W-1:0]  plist_mem [0:PRIME_DEPTH-1];

    logic              mark_rd_reg;
    logic [CW-1:0]     cnt_rd_reg;
    logic [EW-1:0]     exp_rd_reg;
    logic [IDX_W-1:0]  plist_rd_reg;

    logic              mark_we;
    logic [IDX_W-1:0]  mark_wa;
    logic              mark_wd;
    logic              cnt_we;
    logic [IDX_W-1:0]  cnt_wa;
    logic [CW-1:0]     cnt_wd;
    logic              exp_we;
    logic [IDX_W-1:0]  exp_wa;
    logic [EW-1:0]     exp_wd;
    logic              pl_we;

    // Shared divider
    logic              div_start;
    logic [IDX_W-1:0]  div_a;
    logic [IDX_W-1:0]  div_b;
    logic [IDX_W-1:0]  div_quo;
    logic [IDX_W-1:0]  div_rem;
    logic              div_done;

    // Misc
    logic [IDX_W-1:0]  eff_lim;
    logic [IDX_W-1:0]  m_idx;
    logic [CW-1:0]     cnt_dbl;
    logic [CW-1:0]     cnt_scaled;
    logic [EW-1:0]     exp_inc;
    logic              cfg_wr;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[lsdc_pkg::APB_AW-1] == lsdc_pkg::REG_UPPER_LIMIT);

    always_comb
    begin
        if (paddr[lsdc_pkg::APB_AW-1] == lsdc_pkg::REG_UPPER_LIMIT)
        begin
            prdata = DW'(lim_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= lsdc_pkg::UPPER_LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            lim_reg <= pwdata[LIM_W-1:0];
        end
    end

    // Limit clamped to 1..MAX_N
    always_comb
    begin
        if (lim_reg == '0)
        begin
            eff_lim = IDX_W'(1);
        end
        else if (CMP_W'(lim_reg) > CMP_W'(MAX_N))
        begin
            eff_lim = IDX_W'(MAX_N);
        end
        else
        begin
            eff_lim = IDX_W'(lim_reg);
        end
    end

    // ------------------------------------------------------------------------
    // Table update values
    // ------------------------------------------------------------------------
    assign m_idx = prod_reg[IDX_W-1:0];

    // count * 2 with saturation (count of a prime is always 2)
    assign cnt_dbl = ci_reg[CW-1] ? lsdc_pkg::COUNT_MAX : {ci_reg[CW-2:0], 1'b0};

    // count / (e+1) * (e+2) with saturation
    assign cnt_scaled = (cmul_reg > CMUL_W'(lsdc_pkg::COUNT_MAX)) ? lsdc_pkg::COUNT_MAX
                                                                   : cmul_reg[CW-1:0];

    assign exp_inc = (ei_reg == lsdc_pkg::EXP_MAX) ? lsdc_pkg::EXP_MAX
                                                   : ei_reg + EW'(1);

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        cur_next          = cur_reg;
        pt_next           = pt_reg;
        j_next            = j_reg;
        sweep_next        = sweep_reg;
        dirty_top_next    = dirty_top_reg;
        restart_pend_next = restart_pend_reg;
        ci_next           = ci_reg;
        ei_next           = ei_reg;
        p_next            = p_reg;
        prod_next         = prod_reg;
        cmul_next         = cmul_reg;
        out_load          = 1'b0;

        mark_we = 1'b0;
        mark_wa = m_idx;
        mark_wd = 1'b1;
        cnt_we  = 1'b0;
        cnt_wa  = m_idx;
        cnt_wd  = cnt_dbl;
        exp_we  = 1'b0;
        exp_wa  = m_idx;
        exp_wd  = lsdc_pkg::EXP_PRIME;
        pl_we   = 1'b0;

        div_start = 1'b0;
        div_a     = cur_reg;
        div_b     = p_reg;

        unique case (state_reg)
            // Clear composite marks, top down
            S_CLR:
            begin
                mark_we = 1'b1;
                mark_wa = sweep_reg;
                mark_wd = 1'b0;
                if (sweep_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg - IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (restart)
                    begin
                        cur_next          = IDX_W'(1);
                        pt_next           = '0;
                        ci_next           = lsdc_pkg::COUNT_ONE;
                        restart_pend_next = 1'b1;
                        state_next        = S_OUT;
                    end
                    else if (cur_reg < eff_lim)
                    begin
                        cur_next   = cur_reg + IDX_W'(1);
                        state_next = S_RD;
                    end
                end
            end

            // Table reads at the new index are in flight
            S_RD:
            begin
                state_next = S_CHK;
            end

            // Unmarked index is a prime
            S_CHK:
            begin
                j_next = '0;
                if (!mark_rd_reg)
                begin
                    cnt_we  = 1'b1;
                    cnt_wa  = cur_reg;
                    cnt_wd  = lsdc_pkg::COUNT_PRIME;
                    exp_we  = 1'b1;
                    exp_wa  = cur_reg;
                    exp_wd  = lsdc_pkg::EXP_PRIME;
                    ci_next = lsdc_pkg::COUNT_PRIME;
                    ei_next = lsdc_pkg::EXP_PRIME;
                    if (pt_reg < PT_W'(PRIME_DEPTH))
                    begin
                        pl_we   = 1'b1;
                        pt_next = pt_reg + PT_W'(1);
                    end
                end
                else
                begin
                    ci_next = cnt_rd_reg;
                    ei_next = exp_rd_reg;
                end
                state_next = S_PRD;
            end

            // Fetch next prime, or finish at the end of the list
            S_PRD:
            begin
                if (j_reg >= pt_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_PMUL;
                end
            end

            S_PMUL:
            begin
                p_next     = plist_rd_reg;
                prod_next  = PROD_W'(cur_reg) * PROD_W'(plist_rd_reg);
                state_next = S_PCMP;
            end

            // Stop past the limit; otherwise mark and test divisibility
            S_PCMP:
            begin
                if ((p_reg == '0) || (prod_reg > PROD_W'(eff_lim)))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    mark_we = 1'b1;
                    if (m_idx > dirty_top_reg)
                    begin
                        dirty_top_next = m_idx;
                    end
                    div_start  = 1'b1;
                    state_next = S_PDIV;
                end
            end

            S_PDIV:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        div_start  = 1'b1;
                        div_a      = IDX_W'(ci_reg);
                        div_b      = IDX_W'(ei_reg) + IDX_W'(1);
                        state_next = S_CDIV;
                    end
                    else
                    begin
                        cnt_we     = 1'b1;
                        exp_we     = 1'b1;
                        j_next     = j_reg + PT_W'(1);
                        state_next = S_PRD;
                    end
                end
            end

            S_CDIV:
            begin
                if (div_done)
                begin
                    cmul_next  = CMUL_W'(CW'(div_quo))
                                 * CMUL_W'({1'b0, ei_reg} + (EW + 1)'(2));
                    state_next = S_CWR;
                end
            end

            S_CWR:
            begin
                cnt_we     = 1'b1;
                cnt_wd     = cnt_scaled;
                exp_we     = 1'b1;
                exp_wd     = exp_inc;
                state_next = S_OUT;
            end

            // Hand the result to the output register
            S_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_load = 1'b1;
                    if (restart_pend_reg)
                    begin
                        restart_pend_next = 1'b0;
                        sweep_next        = dirty_top_reg;
                        dirty_top_next    = '0;
                        state_next        = S_CLR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLR;
            cur_reg          <= IDX_W'(1);
            pt_reg           <= '0;
            j_reg            <= '0;
            sweep_reg        <= IDX_W'(MAX_N);
            dirty_top_reg    <= '0;
            restart_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_reg          <= cur_next;
            pt_reg           <= pt_next;
            j_reg            <= j_next;
            sweep_reg        <= sweep_next;
            dirty_top_reg    <= dirty_top_next;
            restart_pend_reg <= restart_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ci_reg   <= ci_next;
        ei_reg   <= ei_next;
        p_reg    <= p_next;
        prod_reg <= prod_next;
        cmul_reg <= cmul_next;
    end

    // ------------------------------------------------------------------------
    // Tables: one write and one registered read per cycle each
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_wa] <= mark_wd;
        end
        mark_rd_reg <= mark_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_rd_reg <= cnt_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (exp_we)
        begin
            exp_mem[exp_wa] <= exp_wd;
        end
        exp_rd_reg <= exp_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (pl_we)
        begin
            plist_mem[pt_reg[PL_AW-1:0]] <= cur_reg;
        end
        plist_rd_reg <= plist_mem[j_reg[PL_AW-1:0]];
    end

    // ------------------------------------------------------------------------
    // Shared divider: divisibility test and count rescale
    // ------------------------------------------------------------------------
    lsdc_div #(
        .W (IDX_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_idx_reg  <= cur_reg;
            out_cnt_reg  <= ci_reg;
            out_last_reg <= (cur_reg == eff_lim);
        end
    end

    assign item_stall    = (state_reg != S_IDLE);
    assign result_valid  = out_valid_reg;
    assign index         = out_idx_reg;
    assign divisor_count = out_cnt_reg;
    assign last          = out_last_reg;

endmodule
